@@ hw/rtl/olst_pkg.sv @@
// Shared constants, codes and types of the ordered list engine.
package olst_pkg;

  localparam int OLST_CAPACITY = 16;

  // Request codes on the input channel.
  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK  = 3'd1;
  localparam logic [2:0] REQ_INS_POS   = 3'd2;
  localparam logic [2:0] REQ_DEL_VAL   = 3'd3;
  localparam logic [2:0] REQ_DEL_POS   = 3'd4;
  localparam logic [2:0] REQ_UPDATE    = 3'd5;
  localparam logic [2:0] REQ_FIND      = 3'd6;

  // Status codes on the output channel.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // How the target position of a request is chosen.
  localparam logic [1:0] POS_GIVEN = 2'd0;
  localparam logic [1:0] POS_FIRST = 2'd1;
  localparam logic [1:0] POS_LAST  = 2'd2;

  // A decoded request as it travels from the front to the back.
  typedef struct packed {
    logic               is_insert;
    logic               is_delete;
    logic               is_update;
    logic               is_find;
    logic               by_value;
    logic [1:0]         pos_sel;
    logic signed [31:0] value;
    logic [4:0]         pos;
  } op_t;

endpackage

@@ hw/rtl/olst_if.sv @@
// Valid/ready channels for requests and responses of the ordered list engine.
interface olst_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] item_value;
  logic [4:0]         position;

  modport source (output valid, req_type, item_value, position, input ready);
  modport sink (input valid, req_type, item_value, position, output ready);
endinterface

interface olst_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] entry_pos;
  logic [4:0] list_length;

  modport source (output valid, status, entry_pos, list_length, input ready);
  modport sink (input valid, status, entry_pos, list_length, output ready);
endinterface

@@ hw/rtl/olst_front.sv @@
// Front end: decodes request words and holds them in a two-entry queue.
module olst_front
  import olst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  olst_req_if.sink    req,
  output logic        q_valid,
  output op_t         q_op,
  input  logic        q_pop
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  op_t        dec;
  logic       push;

  // Turn the request code into operation flags and a position choice.
  always_comb begin
    dec           = '0;
    dec.value     = req.item_value;
    dec.pos       = req.position;
    dec.pos_sel   = POS_GIVEN;
    case (req.req_type)
      REQ_INS_FRONT: begin
        dec.is_insert = 1'b1;
        dec.pos_sel   = POS_FIRST;
      end
      REQ_INS_BACK: begin
        dec.is_insert = 1'b1;
        dec.pos_sel   = POS_LAST;
      end
      REQ_INS_POS: dec.is_insert = 1'b1;
      REQ_DEL_VAL: begin
        dec.is_delete = 1'b1;
        dec.by_value  = 1'b1;
      end
      REQ_DEL_POS: dec.is_delete = 1'b1;
      REQ_UPDATE:  dec.is_update = 1'b1;
      REQ_FIND:    dec.is_find   = 1'b1;
      default:     dec.is_find   = 1'b0;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_op      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (q_pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/olst_back.sv @@
// Back end: the entry cells, the compare stage and the commit stage with the result register.
module olst_back
  import olst_pkg::*;
#(
  parameter int CAPACITY = OLST_CAPACITY
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_pop,
  olst_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;
  localparam int IW = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_INS  = 2'd1;
  localparam logic [1:0] ACT_DEL  = 2'd2;
  localparam logic [1:0] ACT_UPD  = 2'd3;

  logic [1:0]         state;
  op_t                op;
  logic [CAPACITY-1:0] matchv;
  logic [CW-1:0]      cnt;
  logic signed [31:0] cells [CAPACITY];
  logic signed [31:0] prev_v [CAPACITY];
  logic signed [31:0] next_v [CAPACITY];

  logic               out_valid;
  logic [2:0]         out_status;
  logic [4:0]         out_pos;
  logic [4:0]         out_len;

  logic               fire;
  logic [PW-1:0]      cnt_ext;
  logic [PW-1:0]      pos_e;
  logic               hit;
  logic [IW-1:0]      hit_idx;
  logic [1:0]         act;
  logic [PW-1:0]      k;
  logic [2:0]         st;
  logic [PW-1:0]      at;
  logic [CW-1:0]      cnt_next;

  assign fire  = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign q_pop = q_valid && ((state == S_IDLE) || fire);

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_pos   = out_pos;
  assign rsp.list_length = out_len;

  // Neighbor taps of every cell for shifting up and down.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign prev_v[g] = cells[g];
    end else begin : g_rest
      assign prev_v[g] = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_v[g] = cells[g];
    end else begin : g_mid
      assign next_v[g] = cells[g+1];
    end
  end

  // First matching cell.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (matchv[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_comb begin
    cnt_ext  = PW'(cnt);
    case (op.pos_sel)
      POS_FIRST: pos_e = PW'(1);
      POS_LAST:  pos_e = cnt_ext + PW'(1);
      default:   pos_e = PW'(op.pos);
    endcase
    act      = ACT_NONE;
    k        = pos_e - PW'(1);
    st       = ST_OK;
    at       = '0;
    cnt_next = cnt;
    if (op.is_insert) begin
      if (pos_e == '0 || pos_e > cnt_ext + PW'(1)) begin
        st = ST_BADPOS;
      end else if (cnt_ext >= PW'(CAPACITY)) begin
        st = ST_FULL;
      end else begin
        act      = ACT_INS;
        at       = pos_e;
        cnt_next = cnt + CW'(1);
      end
    end else if (op.is_delete || op.is_update || op.is_find) begin
      if (cnt == '0) begin
        st = ST_EMPTY;
      end else if (op.by_value || op.is_find) begin
        if (!hit) begin
          st = ST_NOTFOUND;
        end else begin
          at = PW'(hit_idx) + PW'(1);
          k  = PW'(hit_idx);
          if (op.is_delete) begin
            act      = ACT_DEL;
            cnt_next = cnt - CW'(1);
          end
        end
      end else if (pos_e == '0 || pos_e > cnt_ext) begin
        st = ST_BADPOS;
      end else begin
        at = pos_e;
        if (op.is_delete) begin
          act      = ACT_DEL;
          cnt_next = cnt - CW'(1);
        end else begin
          act = ACT_UPD;
        end
      end
    end
  end

  // Cells and the compare stage.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op <= q_op;
    end
    if (state == S_CMP) begin
      for (int i = 0; i < CAPACITY; i++) begin
        matchv[i] <= (cells[i] == op.value) && (PW'(i) < PW'(cnt));
      end
    end
    if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        case (act)
          ACT_INS: begin
            if (PW'(i) == k) begin
              cells[i] <= op.value;
            end else if (PW'(i) > k) begin
              cells[i] <= prev_v[i];
            end
          end
          ACT_DEL: begin
            if (PW'(i) >= k) begin
              cells[i] <= next_v[i];
            end
          end
          ACT_UPD: begin
            if (PW'(i) == k) begin
              cells[i] <= op.value;
            end
          end
          default: cells[i] <= cells[i];
        endcase
      end
      out_status <= st;
      out_pos    <= at[4:0];
      out_len    <= 5'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        state <= S_CMP;
      end else if (state == S_CMP) begin
        state <= S_EXEC;
      end else if (fire) begin
        state <= S_IDLE;
      end
      if (fire) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    PW'(cnt) <= PW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_pos_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.entry_pos == 5'd0)
    else $error("position reported with an error status");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt == $past(cnt)) || (cnt == $past(cnt) + CW'(1))
                    || (cnt + CW'(1) == $past(cnt)))
    else $error("entry count changed by more than one");

  a_exec_after_cmp: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |=> state == S_EXEC)
    else $error("compare stage not followed by commit");

  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) || fire)
    else $error("request taken while back end busy");

endmodule

@@ hw/rtl/ordered_list_engine.sv @@
// Top level of the ordered list engine: an ordered store of signed 32-bit values.
//
// Requests arrive as words on the req channel (valid/ready): insert at the
// front, at the back or at a 1-based position, delete the first entry equal
// to a value, delete at a position, overwrite at a position, or find a value.
// Every request yields exactly one response word on the rsp channel with a
// status, the position touched or found (zero on any error), and the length.
//
// The front end decodes each request and parks it in a two-entry queue. The
// back end takes one request at a time: a compare step checks every cell
// against the value in parallel, then a commit step priority-encodes the first
// match, shifts or writes the cells and loads the response register. The back
// end cannot take a new request before it is through with the last one, but it
// takes the next one from the queue as it commits, and the commit step waits
// while the receiver has not taken the previous response.
//
// Reset clears the entry count, the queue and the response register; cell
// contents are undefined until written. When the receiver stalls, the
// response register holds its word, the back end waits in its commit step,
// and the queue absorbs up to two more requests before req.ready drops.
module ordered_list_engine
  import olst_pkg::*;
#(
  parameter int CAPACITY = OLST_CAPACITY
)
(
  input  logic       clk,
  input  logic       rst,
  olst_req_if.sink   req,
  olst_rsp_if.source rsp
);

  logic q_valid;
  logic q_pop;
  op_t  q_op;

  // Decode and queue incoming requests.
  olst_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  // Compare, commit and respond.
  olst_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule
